[rtl/spma_pkg.sv]
package spma_pkg;

  // Full-scale code of the 12-bit pulse and average domain.
  localparam logic [11:0] FULL_SCALE = 12'd4095;

  // Reciprocal of 4095 for products below 2**24: floor(x / 4095) is
  // (x * FS_RECIP) >> FS_SHIFT, exact over that whole range.
  localparam int          FS_SHIFT = 36;
  localparam logic [24:0] FS_RECIP = 25'd16781314;

  // Register reset values.
  localparam logic [15:0] PERIOD_RST    = 16'd20000;
  localparam logic [11:0] BASE_RST      = 12'd1000;
  localparam logic [11:0] SPAN_RST      = 12'd1000;
  localparam logic [11:0] ZONE_LOW_RST  = 12'd1365;
  localparam logic [11:0] ZONE_HIGH_RST = 12'd2730;
  localparam logic [11:0] WIDTH_RST     = 12'd1500;

  // LED patterns.
  localparam logic [2:0] LED_OFF  = 3'b000;
  localparam logic [2:0] LED_LOW  = 3'b001;
  localparam logic [2:0] LED_MID  = 3'b010;
  localparam logic [2:0] LED_HIGH = 3'b100;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PERIOD_TICKS = 3'd0,
    CFG_PULSE_BASE   = 3'd1,
    CFG_PULSE_SPAN   = 3'd2,
    CFG_ZONE_LOW     = 3'd3,
    CFG_ZONE_HIGH    = 3'd4
  } cfg_idx_t;

  // Pipeline control handed to the sample ring.
  typedef struct packed {
    logic load;   // the first stage takes a new beat (or a bubble)
    logic take;   // the beat accepted now is an ADC sample
    logic drain;  // the first stage hands its beat on
  } ring_ctl_t;

endpackage

[rtl/spma_ring.sv]
module spma_ring #(
  parameter int RING_DEPTH  = 20,
  parameter int SAMPLE_BITS = 12,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spma_pkg::ring_ctl_t   ctl,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SUM_W-1:0]      sum_o
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_MAX =
    SUM_W'(RING_DEPTH * ((1 << SAMPLE_BITS) - 1));

  // Sample store, one read and one write per cycle.
  logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]  vbit_r;

  logic [PTR_W-1:0]       wr_pos_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;

  // First stage: the sample, its slot and the old entry read from the store.
  logic                   p1_smp_r;
  logic [PTR_W-1:0]       p1_addr_r;
  logic [SAMPLE_BITS-1:0] p1_sample_r;
  logic [SAMPLE_BITS-1:0] rd_q_r;
  logic                   rd_ok_r;
  logic                   p1_fwd_r;
  logic [SAMPLE_BITS-1:0] p1_fwd_data_r;
  logic [SAMPLE_BITS-1:0] old_val;

  // The oldest entry: forwarded when the slot was written in the same cycle
  // as it was read, zero when the slot has not been written since reset.
  always_comb begin
    if (p1_fwd_r) begin
      old_val = p1_fwd_data_r;
    end else if (rd_ok_r) begin
      old_val = rd_q_r;
    end else begin
      old_val = '0;
    end
    sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(p1_sample_r);
  end

  // Control state: slot pointer, valid bits, running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      vbit_r   <= '0;
      sum_r    <= '0;
      p1_smp_r <= 1'b0;
      p1_fwd_r <= 1'b0;
      rd_ok_r  <= 1'b0;
    end else begin
      if (ctl.load) begin
        p1_smp_r <= ctl.take;
        p1_fwd_r <= ctl.take && ctl.drain && p1_smp_r && (p1_addr_r == wr_pos_r);
        rd_ok_r  <= vbit_r[wr_pos_r];
        if (ctl.take) begin
          wr_pos_r <= (wr_pos_r == LAST_POS) ? '0 : wr_pos_r + 1'b1;
        end
      end
      if (ctl.drain && p1_smp_r) begin
        vbit_r[p1_addr_r] <= 1'b1;
        sum_r             <= sum_nxt;
      end
    end
  end

  // Store access and first-stage payload.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p1_addr_r     <= wr_pos_r;
      p1_sample_r   <= sample_i;
      p1_fwd_data_r <= p1_sample_r;
      rd_q_r        <= mem[wr_pos_r];
    end
    if (ctl.drain && p1_smp_r) begin
      mem[p1_addr_r] <= p1_sample_r;
    end
  end

  assign sum_o = sum_r;

  // A slot can only be read while still being written when the ring has
  // one entry.
  a_fwd_only_single: assert property (@(posedge clk) disable iff (!rst_n)
    p1_fwd_r |-> (p1_smp_r && (RING_DEPTH == 1)))
    else $error("ring forwarding on a ring deeper than one entry");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pos_r <= LAST_POS)
    else $error("ring write pointer out of range");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.drain && p1_smp_r) |=> (sum_r <= SUM_MAX))
    else $error("running sum exceeds the ring's full-scale total");

endmodule

[rtl/servo_pwm_moving_average.sv]
// Servo PWM driver fed by a moving average of ADC samples.
//
// Input channel (in_valid/in_ready): each beat is either an ADC sample
// (in_mode 0, in_sample used) or one microsecond tick (in_mode 1). Every
// input beat gives exactly one result beat on the output channel
// (out_valid/out_ready): pin level, pulse width, average and LED pattern
// as they stand after that item.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
// high; the user must see that registers are written while the block is idle,
// as the block itself does not enforce it.
// Throughput: one item per cycle unless a stall on out_ready fills every stage.
// The sample ring takes one read and one write per cycle, and the running sum
// is updated once per cycle, which sets that rate. The result is registered
// through the ring read, sum, reciprocal multiply for the mean, span multiply,
// reciprocal multiply for the mapping and the final update, in that order.
// Reset: configuration and state registers return to their defaults and the ring
// reads as zeros at once through per-entry valid bits; no clearing pass.
// Stall: while out_ready is low the result holds; earlier stages keep
// filling bubbles, and in_ready falls only once every stage is occupied.
module servo_pwm_moving_average #(
  parameter int RING_DEPTH  = 20,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_servo_level,
  output logic [11:0]            out_pulse_width,
  output logic [11:0]            out_average,
  output logic [2:0]             out_led_pattern,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int LOG_D        = $clog2(RING_DEPTH);
  localparam int SUM_W        = SAMPLE_BITS + LOG_D;
  localparam int MEAN_SHIFT   = SUM_W + LOG_D;
  localparam int MEAN_RECIP_W = SUM_W + 1;
  localparam int PROD1_W      = SUM_W + MEAN_RECIP_W;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
    MEAN_RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  // Configuration registers.
  logic [15:0] period_r;
  logic [11:0] base_r;
  logic [11:0] span_r;
  logic [11:0] zone_low_r;
  logic [11:0] zone_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= spma_pkg::PERIOD_RST;
      base_r      <= spma_pkg::BASE_RST;
      span_r      <= spma_pkg::SPAN_RST;
      zone_low_r  <= spma_pkg::ZONE_LOW_RST;
      zone_high_r <= spma_pkg::ZONE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spma_pkg::CFG_PERIOD_TICKS: period_r    <= cfg_data;
        spma_pkg::CFG_PULSE_BASE:   base_r      <= cfg_data[11:0];
        spma_pkg::CFG_PULSE_SPAN:   span_r      <= cfg_data[11:0];
        spma_pkg::CFG_ZONE_LOW:     zone_low_r  <= cfg_data[11:0];
        spma_pkg::CFG_ZONE_HIGH:    zone_high_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Stage occupancy and the elastic advance chain.
  logic p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r, p5_vld_r, out_valid_r;
  logic p1_mode_r, p2_mode_r, p3_mode_r, p4_mode_r, p5_mode_r;
  logic en1, en2, en3, en4, en5, en_out;
  logic in_acc;

  assign en_out = !out_valid_r || out_ready;
  assign en5    = !p5_vld_r || en_out;
  assign en4    = !p4_vld_r || en5;
  assign en3    = !p3_vld_r || en4;
  assign en2    = !p2_vld_r || en3;
  assign en1    = !p1_vld_r || en2;
  assign in_ready = en1;
  assign in_acc   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      p5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    p1_vld_r    <= in_valid;
      if (en2)    p2_vld_r    <= p1_vld_r;
      if (en3)    p3_vld_r    <= p2_vld_r;
      if (en4)    p4_vld_r    <= p3_vld_r;
      if (en5)    p5_vld_r    <= p4_vld_r;
      if (en_out) out_valid_r <= p5_vld_r;
    end
  end

  // Sample ring and running sum.
  spma_pkg::ring_ctl_t    ring_ctl;
  logic [SUM_W-1:0]       ring_sum;

  assign ring_ctl.load  = en1;
  assign ring_ctl.take  = in_acc && !in_mode;
  assign ring_ctl.drain = en2;

  spma_ring #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ring_ctl),
    .sample_i (in_sample),
    .sum_o    (ring_sum)
  );

  // Mean and pulse-width arithmetic, one multiply per stage.
  logic [PROD1_W-1:0]     p3_prod1_r;
  logic [23:0]            p4_prod2_r;
  logic [11:0]            p4_mean_r;
  logic [48:0]            p5_prod3_r;
  logic [11:0]            p5_mean_r;
  logic [SAMPLE_BITS-1:0] mean_q;
  logic [15:0]            mean_q16;
  logic [11:0]            mean_nxt;

  // Truncated mean, clamped to full scale for wide samples.
  always_comb begin
    mean_q   = p3_prod1_r[MEAN_SHIFT +: SAMPLE_BITS];
    mean_q16 = 16'(mean_q);
    if (mean_q16 > 16'(spma_pkg::FULL_SCALE)) begin
      mean_nxt = spma_pkg::FULL_SCALE;
    end else begin
      mean_nxt = mean_q16[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p2_mode_r <= p1_mode_r;
    end
    if (en1) begin
      p1_mode_r <= in_mode;
    end
    if (en3) begin
      p3_mode_r  <= p2_mode_r;
      p3_prod1_r <= PROD1_W'(ring_sum) * PROD1_W'(MEAN_RECIP);
    end
    if (en4) begin
      p4_mode_r  <= p3_mode_r;
      p4_mean_r  <= mean_nxt;
      p4_prod2_r <= 24'(mean_nxt) * 24'(span_r);
    end
    if (en5) begin
      p5_mode_r  <= p4_mode_r;
      p5_mean_r  <= p4_mean_r;
      p5_prod3_r <= 49'(p4_prod2_r) * 49'(spma_pkg::FS_RECIP);
    end
  end

  // Final stage: block state, which is also the result beat.
  logic        pin_r;
  logic [11:0] width_r;
  logic [11:0] mean_r;
  logic [2:0]  led_r;
  logic [15:0] count_r;

  logic [11:0] span_q;
  logic [12:0] width_sum;
  logic [11:0] width_nxt;
  logic [2:0]  led_nxt;
  logic [15:0] count_inc;
  logic [15:0] count_nxt;
  logic        pin_nxt;

  always_comb begin
    span_q    = p5_prod3_r[spma_pkg::FS_SHIFT +: 12];
    width_sum = {1'b0, base_r} + {1'b0, span_q};
    if (width_sum > 13'(spma_pkg::FULL_SCALE)) begin
      width_nxt = spma_pkg::FULL_SCALE;
    end else begin
      width_nxt = width_sum[11:0];
    end

    // Zones in order; at full scale the LEDs keep their pattern.
    if (width_nxt < zone_low_r) begin
      led_nxt = spma_pkg::LED_LOW;
    end else if (width_nxt < zone_high_r) begin
      led_nxt = spma_pkg::LED_MID;
    end else if (width_nxt < spma_pkg::FULL_SCALE) begin
      led_nxt = spma_pkg::LED_HIGH;
    end else begin
      led_nxt = led_r;
    end

    // Period counter: wrap raises the pin, a width match lowers it.
    count_inc = count_r + 16'd1;
    pin_nxt   = pin_r;
    count_nxt = count_inc;
    if (count_inc >= period_r) begin
      count_nxt = '0;
      pin_nxt   = 1'b1;
    end
    if (count_nxt == 16'(width_r)) begin
      pin_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r   <= 1'b0;
      width_r <= spma_pkg::WIDTH_RST;
      mean_r  <= '0;
      led_r   <= spma_pkg::LED_OFF;
      count_r <= '0;
    end else if (en_out && p5_vld_r) begin
      if (p5_mode_r) begin
        pin_r   <= pin_nxt;
        count_r <= count_nxt;
      end else begin
        width_r <= width_nxt;
        mean_r  <= p5_mean_r;
        led_r   <= led_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_level = pin_r;
  assign out_pulse_width = width_r;
  assign out_average     = mean_r;
  assign out_led_pattern = led_r;

  // A tick that lands the counter on the pulse width always leaves the pin low.
  a_match_low: assert property (@(posedge clk) disable iff (!rst_n)
    (en_out && p5_vld_r && p5_mode_r && (count_nxt == 16'(width_r))) |=> !pin_r)
    else $error("servo pin high after a tick that matched the pulse width");

  a_led_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(led_r))
    else $error("LED pattern lights more than one zone");

  // Input back-pressure only when every stage holds a beat.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (p1_vld_r && p2_vld_r && p3_vld_r && p4_vld_r && p5_vld_r
                   && out_valid_r && !out_ready))
    else $error("input stalled with a bubble in the pipeline");

endmodule

[tb/sv/servo_pwm_moving_average_tb.sv]
module servo_pwm_moving_average_tb;

  localparam int RING_N          = 20;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int PRESSURE_PHASE  = 5;
  localparam int HOLD_CYCLES     = 150;
  localparam int DRAIN_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 40;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef struct {
    logic        mode;
    logic [11:0] sample;
  } servo_item_t;

  typedef struct {
    logic        level;
    logic [11:0] width;
    logic [11:0] avg;
    logic [2:0]  leds;
  } servo_status_t;

  // Clock, reset and block ports.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [11:0] in_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_servo_level;
  logic [11:0] out_pulse_width;
  logic [11:0] out_average;
  logic [2:0]  out_led_pattern;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Settings held by the predictor.
  logic [15:0] period_m = spma_pkg::PERIOD_RST;
  logic [11:0] base_m   = spma_pkg::BASE_RST;
  logic [11:0] span_m   = spma_pkg::SPAN_RST;
  logic [11:0] zlow_m   = spma_pkg::ZONE_LOW_RST;
  logic [11:0] zhigh_m  = spma_pkg::ZONE_HIGH_RST;

  // Predicted state of the servo driver.
  logic [11:0] ring_m [RING_N] = '{default: '0};
  logic [4:0]  wr_pos  = '0;
  logic [16:0] sum_m   = '0;
  logic [11:0] width_m = spma_pkg::WIDTH_RST;
  logic [15:0] ticks_m = '0;
  logic        pin_m   = 1'b0;
  logic [2:0]  led_m   = spma_pkg::LED_OFF;

  servo_item_t   pending_items[$];
  servo_status_t expected_status[$];

  int gap_left       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  bit quiet          = 1'b0;
  bit sender_dense   = 1'b0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int beat_count     = 0;

  servo_pwm_moving_average uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_servo_level (out_servo_level),
    .out_pulse_width (out_pulse_width),
    .out_average     (out_average),
    .out_led_pattern (out_led_pattern),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Truncated mean of the predicted ring, clamped to full scale.
  function automatic logic [11:0] ring_mean();
    int unsigned m;
    m = sum_m / RING_N;
    if (m > spma_pkg::FULL_SCALE) m = spma_pkg::FULL_SCALE;
    return m[11:0];
  endfunction

  // Advances the predicted driver by one item and returns the status after it.
  function automatic servo_status_t servo_next(input servo_item_t it);
    servo_status_t r;
    logic [15:0]   cnt;
    int unsigned   wid;
    if (it.mode == MODE_SAMPLE) begin
      // The new sample replaces the oldest ring entry.
      sum_m = sum_m - ring_m[wr_pos] + it.sample;
      ring_m[wr_pos] = it.sample;
      wr_pos = (wr_pos == RING_N - 1) ? 5'd0 : wr_pos + 5'd1;
      wid = base_m + (ring_mean() * span_m) / spma_pkg::FULL_SCALE;
      if (wid > spma_pkg::FULL_SCALE) wid = spma_pkg::FULL_SCALE;
      width_m = wid[11:0];
      // Zones are tried in order; a full-scale width leaves the LEDs alone.
      if (wid < zlow_m) begin
        led_m = spma_pkg::LED_LOW;
      end else if (wid < zhigh_m) begin
        led_m = spma_pkg::LED_MID;
      end else if (wid < spma_pkg::FULL_SCALE) begin
        led_m = spma_pkg::LED_HIGH;
      end
    end else begin
      // A tick: wrap raises the pin, a width match lowers it afterwards.
      cnt = ticks_m + 16'd1;
      if (cnt >= period_m) begin
        cnt = '0;
        pin_m = 1'b1;
      end
      if (cnt == {4'd0, width_m}) pin_m = 1'b0;
      ticks_m = cnt;
    end
    r.level = pin_m;
    r.width = width_m;
    r.avg   = ring_mean();
    r.leds  = led_m;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH cycle %0d beat %0d: %s", cycle_count, beat_count, msg);
  endtask

  task automatic push_item(input logic mode, input logic [11:0] sample);
    servo_item_t it;
    it.mode   = mode;
    it.sample = sample;
    pending_items.push_back(it);
  endtask

  // Returns once nothing is queued, offered or outstanding.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(input spma_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      spma_pkg::CFG_PERIOD_TICKS: period_m = val;
      spma_pkg::CFG_PULSE_BASE:   base_m   = val[11:0];
      spma_pkg::CFG_PULSE_SPAN:   span_m   = val[11:0];
      spma_pkg::CFG_ZONE_LOW:     zlow_m   = val[11:0];
      spma_pkg::CFG_ZONE_HIGH:    zhigh_m  = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] per, input logic [11:0] bas,
                            input logic [11:0] spn, input logic [11:0] zlo,
                            input logic [11:0] zhi);
    cfg_write(spma_pkg::CFG_PERIOD_TICKS, per);
    cfg_write(spma_pkg::CFG_PULSE_BASE, {4'd0, bas});
    cfg_write(spma_pkg::CFG_PULSE_SPAN, {4'd0, spn});
    cfg_write(spma_pkg::CFG_ZONE_LOW, {4'd0, zlo});
    cfg_write(spma_pkg::CFG_ZONE_HIGH, {4'd0, zhi});
    @(negedge clk);
  endtask

  // Input driver: offers queued items, predicting each one as its beat is taken.
  always @(posedge clk) begin : drive_items
    logic        offer;
    servo_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        it.mode   = in_mode;
        it.sample = in_sample;
        expected_status.push_back(servo_next(it));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_mode   <= it.mode;
          in_sample <= it.sample;
          offer = 1'b1;
          gap_left = (quiet || sender_dense) ? 0 : idle_len();
        end
      end
      in_valid <= offer;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin : drain_results
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Checks each result beat against the oldest prediction. Signals are steady
  // at the falling edge, so a beat seen here is taken at the next rising edge.
  always @(negedge clk) begin : check_results
    servo_status_t want;
    if (rst_n && out_valid && out_ready) begin
      beat_count++;
      if (expected_status.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_status.pop_front();
        if (out_servo_level !== want.level)
          report_mismatch($sformatf("servo_level got %0b want %0b",
                                    out_servo_level, want.level));
        if (out_pulse_width !== want.width)
          report_mismatch($sformatf("pulse_width got %0d want %0d",
                                    out_pulse_width, want.width));
        if (out_average !== want.avg)
          report_mismatch($sformatf("average got %0d want %0d", out_average, want.avg));
        if (out_led_pattern !== want.leds)
          report_mismatch($sformatf("led_pattern got %b want %b",
                                    out_led_pattern, want.leds));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] per;
    logic [11:0] bas, spn, zlo, zhi;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: sample extremes, alternating bit patterns and ticks.
    push_item(MODE_TICK, 12'hFFF);
    push_item(MODE_SAMPLE, 12'd0);
    repeat (3) push_item(MODE_SAMPLE, 12'hFFF);
    push_item(MODE_SAMPLE, 12'hAAA);
    push_item(MODE_SAMPLE, 12'h555);
    repeat (2) push_item(MODE_TICK, 12'h5A5);
    wait_idle();

    // Zero width with a short period: the pin rises and falls on one tick.
    set_config(16'd3, 12'd0, 12'd0, 12'd3000, 12'd1000);
    push_item(MODE_SAMPLE, 12'd4095);
    repeat (4) push_item(MODE_TICK, 12'd0);
    wait_idle();

    // Crossed thresholds skip the middle zone; the width is not below the period.
    set_config(16'd3, 12'd2000, 12'd0, 12'd3000, 12'd1000);
    push_item(MODE_SAMPLE, 12'd7);
    repeat (2) push_item(MODE_TICK, 12'hFFF);
    wait_idle();

    // Full-scale width leaves the LEDs as they were; the counter climbs.
    set_config(16'd65535, 12'd4095, 12'd4095, 12'd0, 12'd4095);
    push_item(MODE_SAMPLE, 12'd0);
    repeat (6) push_item(MODE_TICK, 12'd0);
    wait_idle();

    // The period drops below the counter, which must wrap on the next tick.
    set_config(16'd4, 12'd4095, 12'd4095, 12'd0, 12'd4095);
    repeat (2) push_item(MODE_TICK, 12'd0);
    wait_idle();

    // Random phases, each under fresh settings and ending with the block idle.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          per = $urandom_range(1, 40);
          bas = $urandom_range(0, 60);
          spn = $urandom_range(0, 200);
          zlo = $urandom_range(0, 300);
          zhi = $urandom_range(0, 300);
        end
        1: begin
          per = $urandom_range(1, 600);
          bas = $urandom_range(0, 300);
          spn = $urandom_range(0, 600);
          zlo = $urandom_range(0, 1000);
          zhi = $urandom_range(0, 1000);
        end
        2: begin
          per = $urandom_range(0, 1) ? 16'd65535 : 16'd1;
          bas = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          spn = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          zlo = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          zhi = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        end
        default: begin
          per = $urandom_range(1, 65535);
          bas = $urandom_range(0, 4095);
          spn = $urandom_range(0, 4095);
          zlo = $urandom_range(0, 4095);
          zhi = $urandom_range(0, 4095);
        end
      endcase
      set_config(per, bas, spn, zlo, zhi);
      quiet = (p % 5 == 4);
      sender_dense = (p == PRESSURE_PHASE);
      // In the pressure phase the receiver holds off while items keep coming.
      if (sender_dense) hold_req++;
      repeat (ITEMS_PER_PHASE)
        push_item(($urandom_range(0, 99) < 65) ? MODE_TICK : MODE_SAMPLE,
                  $urandom_range(0, 4095));
      wait_idle();
    end
    quiet = 1'b0;
    sender_dense = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/spma_pkg.sv
rtl/spma_ring.sv
rtl/servo_pwm_moving_average.sv
tb/sv/servo_pwm_moving_average_tb.sv
